// File: rtl/rpv_pkg.sv
// Shared types, codes and constants for the RADIUS packet validator.
package rpv_pkg;

   // Default geometry of the datagram.
   localparam int HEADER_BYTES_DEF = 20;
   localparam int CODE_LIMIT_DEF   = 52;
   localparam int DIGEST_BYTES_DEF = 16;

   // Every attribute starts with a type byte and a length byte.
   localparam int ATTR_HEADER_BYTES = 2;

   // Special header code and attribute types.
   localparam logic [7:0] CODE_STATUS_SERVER = 8'd12;
   localparam logic [7:0] TYPE_EAP_MESSAGE   = 8'd79;
   localparam logic [7:0] TYPE_AUTHENTICATOR = 8'd80;

   // Saturation points of the counters.
   localparam logic [15:0] POSITION_MAX = 16'hFFFF;
   localparam logic [14:0] COUNT_MAX    = 15'h7FFF;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_REQUIRE_AUTH = 1'b0,
      CSR_MAX_ATTR     = 1'b1
   } csr_index_type;

   // Failure kinds, in priority order.
   typedef enum logic [3:0] {
      FAIL_NONE          = 4'd0,
      FAIL_SHORT_DGRAM   = 4'd1,
      FAIL_UNKNOWN_CODE  = 4'd2,
      FAIL_SHORT_LENGTH  = 4'd3,
      FAIL_TRUNCATED     = 4'd4,
      FAIL_ATTR_HDR_OVF  = 4'd5,
      FAIL_ATTR_ZERO     = 4'd6,
      FAIL_ATTR_SHORT    = 4'd7,
      FAIL_ATTR_OVF      = 4'd8,
      FAIL_AUTH_LENGTH   = 4'd9,
      FAIL_TOO_MANY_ATTR = 4'd10,
      FAIL_MISSING_AUTH  = 4'd11
   } failure_type;

   // One input item: a datagram byte with its end mark.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   // One result item: the verdict for a datagram.
   typedef struct packed {
      logic        verdict_ok;
      logic [3:0]  failure_code;
      logic [7:0]  packet_code;
      logic [7:0]  packet_ident;
      logic [15:0] effective_length;
      logic [14:0] attribute_count;
   } rsp_payload_type;

endpackage

// File: rtl/radius_packet_validator.sv
// Streaming RADIUS datagram validator: header capture, attribute walk and verdict.
//
//   channel  direction  handshake                   payload
//   req      in         req_valid / req_stall       rpv_pkg::req_payload_type
//   rsp      out        rsp_valid / rsp_stall       rpv_pkg::rsp_payload_type
//   csr      in         csr_write_enable            csr_index, csr_write_data
//
// One byte item is taken per clock while req_stall is low. Each item passes an input
// register and is checked by the walk logic; for a marked last byte the verdict is
// then written to the result register. Reset is synchronous and clears the stage
// valids, the configuration and the per-datagram state. A stalled verdict holds the
// result register; bytes keep flowing until a second last byte meets the occupied
// result register.
module radius_packet_validator #(
   parameter int HEADER_BYTES = rpv_pkg::HEADER_BYTES_DEF,
   parameter int CODE_LIMIT   = rpv_pkg::CODE_LIMIT_DEF,
   parameter int DIGEST_BYTES = rpv_pkg::DIGEST_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rpv_pkg::req_payload_type req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rpv_pkg::rsp_payload_type rsp_payload,
   input  logic                    csr_write_enable,
   input  logic [0:0]              csr_index,
   input  logic [15:0]             csr_write_data
);

   // Configuration registers.
   logic        require_auth_ff;
   logic [15:0] max_attr_ff;

   // Input stage.
   logic                     s1_valid_ff;
   rpv_pkg::req_payload_type s1_item_ff;

   // Per-datagram state.
   logic [15:0] position_ff, position_in;
   logic [7:0]  hcode_ff, hcode_in;
   logic [7:0]  hident_ff, hident_in;
   logic [15:0] hlen_ff, hlen_in;
   logic [16:0] offset_ff, offset_in;
   logic [7:0]  attr_type_ff, attr_type_in;
   rpv_pkg::failure_type walk_err_ff, walk_err_in;
   logic [14:0] count_ff, count_in;
   logic        auth_seen_ff, auth_seen_in;
   logic        auth_need_ff, auth_need_in;

   // Result stage.
   logic                     rsp_valid_ff;
   rpv_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic        advance;
   logic        verdict_load;
   logic [7:0]  b;
   logic [16:0] received;
   logic [15:0] eff_len;
   logic        walk_active;
   logic        at_type;
   logic        at_length;
   logic        needed;
   rpv_pkg::failure_type fail;

   // The input stage moves on unless its verdict would overwrite a waiting result.
   assign advance      = s1_valid_ff && !(s1_item_ff.last_byte && rsp_valid_ff && rsp_stall);
   assign verdict_load = advance && s1_item_ff.last_byte;
   assign req_stall    = s1_valid_ff && !advance;
   assign b            = s1_item_ff.data_byte;

   // Header capture, attribute walk and verdict for the byte in the input stage.
   always_comb begin
      hcode_in     = hcode_ff;
      hident_in    = hident_ff;
      hlen_in      = hlen_ff;
      offset_in    = offset_ff;
      attr_type_in = attr_type_ff;
      walk_err_in  = walk_err_ff;
      count_in     = count_ff;
      auth_seen_in = auth_seen_ff;
      auth_need_in = auth_need_ff;

      if (position_ff == 16'd0) begin
         hcode_in = b;
      end else if (position_ff == 16'd1) begin
         hident_in = b;
      end else if (position_ff == 16'd2) begin
         hlen_in = {b, 8'h00};
      end else if (position_ff == 16'd3) begin
         hlen_in = {hlen_ff[15:8], b};
      end

      walk_active = (walk_err_ff == rpv_pkg::FAIL_NONE) &&
                    (position_ff >= 16'(HEADER_BYTES)) && (position_ff < hlen_in);
      at_type     = ({1'b0, position_ff} == offset_ff);
      at_length   = ({2'b00, position_ff} == ({1'b0, offset_ff} + 18'd1));

      if (walk_active && at_type) begin
         if (({1'b0, position_ff} + 17'(rpv_pkg::ATTR_HEADER_BYTES)) > {1'b0, hlen_in}) begin
            walk_err_in = rpv_pkg::FAIL_ATTR_HDR_OVF;
         end else if (b == 8'd0) begin
            walk_err_in = rpv_pkg::FAIL_ATTR_ZERO;
         end else begin
            attr_type_in = b;
         end
      end else if (walk_active && at_length) begin
         if (b < 8'(rpv_pkg::ATTR_HEADER_BYTES)) begin
            walk_err_in = rpv_pkg::FAIL_ATTR_SHORT;
         end else if (({1'b0, offset_ff} + {10'd0, b}) > {2'b00, hlen_in}) begin
            walk_err_in = rpv_pkg::FAIL_ATTR_OVF;
         end else if ((attr_type_ff == rpv_pkg::TYPE_AUTHENTICATOR) &&
                      (b != 8'(rpv_pkg::ATTR_HEADER_BYTES + DIGEST_BYTES))) begin
            walk_err_in = rpv_pkg::FAIL_AUTH_LENGTH;
         end else begin
            if (attr_type_ff == rpv_pkg::TYPE_AUTHENTICATOR) begin
               auth_seen_in = 1'b1;
            end
            if (attr_type_ff == rpv_pkg::TYPE_EAP_MESSAGE) begin
               auth_need_in = 1'b1;
            end
            offset_in = offset_ff + {9'd0, b};
            if (count_ff != rpv_pkg::COUNT_MAX) begin
               count_in = count_ff + 15'd1;
            end
         end
      end

      // Verdict, lowest failure code first.
      received = {1'b0, position_ff} + 17'd1;
      needed   = require_auth_ff || auth_need_in || (hcode_in == rpv_pkg::CODE_STATUS_SERVER);

      if (received < 17'(HEADER_BYTES)) begin
         fail = rpv_pkg::FAIL_SHORT_DGRAM;
      end else if ((hcode_in == 8'd0) || ({1'b0, hcode_in} >= 9'(CODE_LIMIT))) begin
         fail = rpv_pkg::FAIL_UNKNOWN_CODE;
      end else if (hlen_in < 16'(HEADER_BYTES)) begin
         fail = rpv_pkg::FAIL_SHORT_LENGTH;
      end else if (received < {1'b0, hlen_in}) begin
         fail = rpv_pkg::FAIL_TRUNCATED;
      end else if (walk_err_in != rpv_pkg::FAIL_NONE) begin
         fail = walk_err_in;
      end else if ((max_attr_ff != 16'd0) && ({1'b0, count_in} > max_attr_ff)) begin
         fail = rpv_pkg::FAIL_TOO_MANY_ATTR;
      end else if (needed && !auth_seen_in) begin
         fail = rpv_pkg::FAIL_MISSING_AUTH;
      end else begin
         fail = rpv_pkg::FAIL_NONE;
      end

      // Received length saturates, then, on success or a failure from truncation on, is trimmed to the header length.
      eff_len = received[16] ? rpv_pkg::POSITION_MAX : received[15:0];
      if (((fail == rpv_pkg::FAIL_NONE) || (fail >= rpv_pkg::FAIL_TRUNCATED)) &&
          (eff_len > hlen_in)) begin
         eff_len = hlen_in;
      end

      rsp_payload_in.verdict_ok       = (fail == rpv_pkg::FAIL_NONE);
      rsp_payload_in.failure_code     = fail;
      rsp_payload_in.packet_code      = hcode_in;
      rsp_payload_in.packet_ident     = (position_ff >= 16'd1) ? hident_in : 8'd0;
      rsp_payload_in.effective_length = eff_len;
      rsp_payload_in.attribute_count  =
         ((fail >= rpv_pkg::FAIL_SHORT_DGRAM) && (fail <= rpv_pkg::FAIL_TRUNCATED)) ?
         15'd0 : count_in;

      position_in = (position_ff == rpv_pkg::POSITION_MAX) ? position_ff : position_ff + 16'd1;
   end

   // Control state: configuration, stage valids and per-datagram state.
   always_ff @(posedge clock) begin
      if (reset) begin
         require_auth_ff <= 1'b0;
         max_attr_ff     <= 16'd0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         position_ff     <= 16'd0;
         hcode_ff        <= 8'd0;
         hident_ff       <= 8'd0;
         hlen_ff         <= 16'd0;
         offset_ff       <= 17'(HEADER_BYTES);
         attr_type_ff    <= 8'd0;
         walk_err_ff     <= rpv_pkg::FAIL_NONE;
         count_ff        <= 15'd0;
         auth_seen_ff    <= 1'b0;
         auth_need_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (rpv_pkg::csr_index_type'(csr_index))
               rpv_pkg::CSR_REQUIRE_AUTH: require_auth_ff <= csr_write_data[0];
               rpv_pkg::CSR_MAX_ATTR:     max_attr_ff     <= csr_write_data;
               default:                   max_attr_ff     <= max_attr_ff;
            endcase
         end

         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end

         if (verdict_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         // A verdict ends the datagram and clears its state.
         if (verdict_load) begin
            position_ff  <= 16'd0;
            hcode_ff     <= 8'd0;
            hident_ff    <= 8'd0;
            hlen_ff      <= 16'd0;
            offset_ff    <= 17'(HEADER_BYTES);
            attr_type_ff <= 8'd0;
            walk_err_ff  <= rpv_pkg::FAIL_NONE;
            count_ff     <= 15'd0;
            auth_seen_ff <= 1'b0;
            auth_need_ff <= 1'b0;
         end else if (advance) begin
            position_ff  <= position_in;
            hcode_ff     <= hcode_in;
            hident_ff    <= hident_in;
            hlen_ff      <= hlen_in;
            offset_ff    <= offset_in;
            attr_type_ff <= attr_type_in;
            walk_err_ff  <= walk_err_in;
            count_ff     <= count_in;
            auth_seen_ff <= auth_seen_in;
            auth_need_ff <= auth_need_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_item_ff <= req_payload;
      end
      if (verdict_load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: rtl/rpv_checker.sv
// Port-level checks for the RADIUS packet validator, bound to the top level.
module rpv_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input rpv_pkg::rsp_payload_type rsp_payload
);

   // A stalled verdict stays in place.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled verdict changed");

   // The ok flag agrees with the failure code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.verdict_ok ==
                     (rsp_payload.failure_code == rpv_pkg::FAIL_NONE)))
      else $error("verdict flag disagrees with failure code");

   // Header and length failures report no walked attributes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.failure_code >= rpv_pkg::FAIL_SHORT_DGRAM) &&
      (rsp_payload.failure_code <= rpv_pkg::FAIL_TRUNCATED)
      |-> rsp_payload.attribute_count == 15'd0)
      else $error("attribute count on a header failure");

   // Failure codes stay in the defined range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.failure_code <= rpv_pkg::FAIL_MISSING_AUTH)
      else $error("failure code out of range");

   // Reset leaves both channels empty.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("channel busy after reset");

endmodule

bind radius_packet_validator rpv_checker u_rpv_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
